@@ rtl/core/kwsc_pkg.sv @@
// Shared types, command codes and constants for the keyword substitution cipher.
`timescale 1ns / 1ps
`default_nettype none

package kwsc_pkg;

    localparam int ALPHABET_SIZE_DEF = 26;
    localparam logic [7:0] LETTER_BASE = 8'h61;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_KEY   = 2'd1,
        OP_END   = 2'd2,
        OP_TEXT  = 2'd3
    } kwsc_op_t;

    typedef struct packed {
        logic clear_kw;
        logic add_key;
        logic sweep_start;
        logic sweep_step;
        logic close_kw;
        logic latch_text;
        logic emit_direct;
        logic emit_held;
    } kwsc_cmd_t;

    typedef struct packed {
        logic kw_open;
        logic sweep_last;
        logic out_busy;
    } kwsc_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/kwsc_ctrl.sv @@
// Controller state machine: input handshake, table completion sweep and result issue.
`timescale 1ns / 1ps
`default_nettype none

module kwsc_ctrl
    import kwsc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] cmd,
    input  wire kwsc_stat_t stat,
    output kwsc_cmd_t       ctl
);

    typedef enum logic [2:0] {
        S_READY = 3'b001,
        S_FILL  = 3'b010,
        S_EMIT  = 3'b100
    } state_t;

    state_t   state_reg;
    state_t   state_next;
    logic     pend_reg;
    logic     pend_next;
    logic     accept;
    kwsc_op_t op;

    assign op       = kwsc_op_t'(cmd);
    assign in_stall = (state_reg != S_READY) || ((op == OP_TEXT) && stat.out_busy);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        ctl        = '0;
        unique case (state_reg)
            S_READY:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_CLEAR: ctl.clear_kw = 1'b1;
                        OP_KEY:   ctl.add_key = 1'b1;
                        OP_END:
                        begin
                            if (stat.kw_open)
                            begin
                                ctl.sweep_start = 1'b1;
                                pend_next       = 1'b0;
                                state_next      = S_FILL;
                            end
                        end
                        OP_TEXT:
                        begin
                            if (stat.kw_open)
                            begin
                                ctl.sweep_start = 1'b1;
                                ctl.latch_text  = 1'b1;
                                pend_next       = 1'b1;
                                state_next      = S_FILL;
                            end
                            else
                            begin
                                ctl.emit_direct = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                ctl.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    ctl.close_kw = 1'b1;
                    state_next   = pend_reg ? S_EMIT : S_READY;
                end
            end
            S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    ctl.emit_held = 1'b1;
                    pend_next     = 1'b0;
                    state_next    = S_READY;
                end
            end
            default:
            begin
                state_next = S_READY;
                pend_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_READY;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/kwsc_datapath.sv @@
// Datapath: substitution table, used-letter flags, fill and sweep counters, output register.
`timescale 1ns / 1ps
`default_nettype none

module kwsc_datapath
    import kwsc_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] data_byte,
    input  wire logic       out_stall,
    input  wire kwsc_cmd_t  ctl,
    output kwsc_stat_t      stat,
    output logic            out_valid,
    output logic [7:0]      cipher_byte
);

    localparam int IDX_W  = $clog2(ALPHABET_SIZE);
    localparam int FILL_W = $clog2(ALPHABET_SIZE + 1);

    logic [IDX_W-1:0]         tbl_reg [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] used_reg;
    logic [FILL_W-1:0]        fill_reg;
    logic [IDX_W-1:0]         sweep_reg;
    logic                     open_reg;
    logic [7:0]               text_reg;
    logic                     out_valid_reg;
    logic [7:0]               out_reg;

    logic [7:0]       key_off;
    logic             key_alpha;
    logic [IDX_W-1:0] key_idx;
    logic [7:0]       src_byte;
    logic [7:0]       src_off;
    logic             src_alpha;
    logic [IDX_W-1:0] src_idx;
    logic [7:0]       out_next;
    logic             room;
    logic             key_write;
    logic             sweep_write;
    logic             emit;

    assign key_off   = data_byte - LETTER_BASE;
    assign key_alpha = (data_byte >= LETTER_BASE) && (key_off < 8'(ALPHABET_SIZE));
    assign key_idx   = key_off[IDX_W-1:0];

    assign src_byte  = ctl.emit_held ? text_reg : data_byte;
    assign src_off   = src_byte - LETTER_BASE;
    assign src_alpha = (src_byte >= LETTER_BASE) && (src_off < 8'(ALPHABET_SIZE));
    assign src_idx   = src_off[IDX_W-1:0];
    assign out_next  = src_alpha ? (LETTER_BASE + 8'(tbl_reg[src_idx])) : src_byte;

    assign room        = fill_reg < FILL_W'(ALPHABET_SIZE);
    assign key_write   = ctl.add_key && open_reg && key_alpha && !used_reg[key_idx] && room;
    assign sweep_write = ctl.sweep_step && room && !used_reg[sweep_reg];
    assign emit        = ctl.emit_direct || ctl.emit_held;

    assign stat.kw_open    = open_reg;
    assign stat.sweep_last = sweep_reg == IDX_W'(ALPHABET_SIZE - 1);
    assign stat.out_busy   = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign cipher_byte     = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ALPHABET_SIZE; k++)
            begin
                tbl_reg[k] <= IDX_W'(k);
            end
            used_reg      <= '0;
            fill_reg      <= '0;
            sweep_reg     <= '0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear_kw)
            begin
                used_reg <= '0;
                fill_reg <= '0;
                open_reg <= 1'b1;
            end
            if (key_write)
            begin
                tbl_reg[fill_reg[IDX_W-1:0]] <= key_idx;
                used_reg[key_idx]            <= 1'b1;
                fill_reg                     <= fill_reg + 1'b1;
            end
            if (ctl.sweep_start)
            begin
                sweep_reg <= '0;
            end
            if (ctl.sweep_step)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (sweep_write)
            begin
                tbl_reg[fill_reg[IDX_W-1:0]] <= sweep_reg;
                fill_reg                     <= fill_reg + 1'b1;
            end
            if (ctl.close_kw)
            begin
                open_reg <= 1'b0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch_text)
        begin
            text_reg <= data_byte;
        end
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/keyword_substitution_cipher.sv @@
// Top level of the keyword substitution cipher: controller and datapath.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------------
//  input   | in_valid  | in_stall  | cmd[1:0], data_byte[7:0]
//  output  | out_valid | out_stall | cipher_byte[7:0]
//
// Clear, keyword and text items with no keyword open are handled in S_READY.
// End of keyword or text while a keyword is open runs the completion sweep,
// one letter per cycle from the sweep counter, adding each unused letter to
// the table; held text then loads the output register when it is not busy.
// A text item is stalled while an earlier result waits in the output register.
// Reset sets the table to the identity and closes the keyword.
`timescale 1ns / 1ps
`default_nettype none

module keyword_substitution_cipher
    import kwsc_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] cmd,
    input  wire logic [7:0] data_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      cipher_byte
);

    kwsc_cmd_t  ctl;
    kwsc_stat_t stat;

    kwsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat),
        .ctl      (ctl)
    );

    kwsc_datapath #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .out_stall   (out_stall),
        .ctl         (ctl),
        .stat        (stat),
        .out_valid   (out_valid),
        .cipher_byte (cipher_byte)
    );

endmodule

`default_nettype wire
